// ===== rtl/blmb_pkg.sv =====
// Shared types and constants of the bridge-loop MAC block table.
`timescale 1ns / 1ps

package blmb_pkg;

  localparam int unsigned MAC_W   = 48;
  localparam int unsigned VEC_W   = 32;
  localparam int unsigned TIMER_W = 8;

  localparam logic [TIMER_W-1:0] HOLD_TIME_RST = 8'd10;

  typedef enum logic {
    CMD_REPORT = 1'b0,
    CMD_TICK   = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ACT_BLOCK   = 2'd0,
    ACT_UNBLOCK = 2'd1,
    ACT_DROP    = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COUNT,
    ST_SCAN,
    ST_DECIDE,
    ST_FLUSH,
    ST_TREAD,
    ST_TUPD
  } state_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [MAC_W-1:0] mac_addr;
    logic [VEC_W-1:0] port_vector;
    logic             no_vector;
  } in_item_t;

  typedef struct packed {
    action_e          action;
    logic [MAC_W-1:0] out_mac;
    logic [VEC_W-1:0] out_vector;
    logic             out_no_vector;
    logic             last_result;
  } out_item_t;

endpackage

// ===== rtl/bridge_loop_mac_block_table_unit.sv =====
// Top level of the bridge-loop MAC block table: sequencer, slot walk and result path.
`timescale 1ns / 1ps

// The unit keeps up to TABLE_DEPTH MAC addresses that were reported on more
// than one port at once and holds each blocked for the configured hold time
// in scan ticks.
// A report item (cmd 0) with two or more port bits set, or with no_vector
// set, is looked up: a new MAC goes to the lowest free slot and yields a
// block result, a known MAC with more ports than before is refreshed and
// yields a block, and a report that finds the table full yields a drop that
// carries the reported fields. A tick item (cmd 1) decrements every stored
// timer; each entry that reaches zero comes out as an unblock, in ascending
// slot order, and its slot is freed. The final result of an item carries
// last_result. The slot data sit in a table RAM with one write port and
// one read port. A report walks every slot, one slot per cycle, before
// it decides; a report that is not acted on skips the walk. A tick visits
// every slot and reads and rewrites each occupied one; an expiring slot
// waits while a result is held and the output is stalled. The input is
// stalled until the item is finished. A finished result waits in an output register,
// so the next item is taken even while the last result is still stalled.
// The hold time register may be written at any time the unit is idle; its
// reset value is 10, and zero makes an entry last 256 ticks.

module bridge_loop_mac_block_table_unit
  import blmb_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 32,
  parameter int unsigned VECTOR_BITS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // item input
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  in_item_t     in_item_i,
  // result output
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output out_item_t    out_item_o,
  // hold time register write
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [TIMER_W-1:0] cfg_data_i
);

  localparam int unsigned IW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(VECTOR_BITS + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

  // One slot as stored in the table RAM.
  typedef struct packed {
    logic [MAC_W-1:0]       mac;
    logic [VECTOR_BITS-1:0] vec;
    logic                   flag;
    logic [TIMER_W-1:0]     timer;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // ---------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------
  state_e                 state_q, state_d;
  logic [TIMER_W-1:0]     hold_time_q;

  // captured item
  logic [MAC_W-1:0]       item_mac_q;
  logic [VECTOR_BITS-1:0] item_vec_q;
  logic                   item_flag_q;
  logic [CNT_W-1:0]       cnt_q;

  // slot walk
  logic [IW-1:0]          idx_q;
  logic                   rd_done_q;
  logic                   cmp_vld_q;
  logic [IW-1:0]          cmp_idx_q;
  logic                   hit_q;
  logic [IW-1:0]          hit_idx_q;
  logic [VECTOR_BITS-1:0] hit_vec_q;
  logic                   free_q;
  logic [IW-1:0]          free_idx_q;
  logic [TABLE_DEPTH-1:0] valid_q;

  // one held result, so the last of a tick's results can be flagged
  logic                   pend_vld_q;
  out_item_t              pend_q;

  // output register
  logic                   out_vld_q;
  out_item_t              out_q;

  // ---------------------------------------------------------------------
  // Table RAM and shared counter
  // ---------------------------------------------------------------------
  logic               ram_rd_en;
  logic [IW-1:0]      ram_rd_addr;
  logic [ENTRY_W-1:0] ram_rd_data;
  logic               ram_wr_en;
  logic [IW-1:0]      ram_wr_addr;
  entry_t             ram_wr_data;
  entry_t             rd_entry;

  blmb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_slot_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  assign rd_entry = entry_t'(ram_rd_data);

  // The counter serves the reported vector first and the stored vector of
  // the hit slot later, when the two counts are compared.
  logic [VECTOR_BITS-1:0] pc_vec;
  logic [CNT_W-1:0]       pc_cnt;

  assign pc_vec = (state_q == ST_DECIDE) ? hit_vec_q : item_vec_q;

  blmb_popcnt #(
    .WIDTH (VECTOR_BITS)
  ) u_popcnt (
    .vec_i   (pc_vec),
    .count_o (pc_cnt)
  );

  // ---------------------------------------------------------------------
  // Decode helpers
  // ---------------------------------------------------------------------
  logic               in_accept;
  logic               is_last;
  logic               cmp_last;
  logic               act_ok;
  logic               hit_more;
  logic [TIMER_W-1:0] tupd_timer;
  logic               expire;
  logic               out_ld_ok;
  logic               tupd_go;

  assign in_accept  = in_valid_i && (state_q == ST_IDLE);
  assign is_last    = (idx_q == LAST_IDX);
  assign cmp_last   = (cmp_idx_q == LAST_IDX);
  assign act_ok     = (pc_cnt > CNT_W'(1)) || item_flag_q;
  assign hit_more   = (cnt_q > pc_cnt);
  assign tupd_timer = rd_entry.timer - TIMER_W'(1);
  assign expire     = (tupd_timer == '0);
  assign out_ld_ok  = !out_vld_q || !out_stall_i;
  // An expiring slot must first push the held result out.
  assign tupd_go    = !expire || !pend_vld_q || out_ld_ok;

  // ---------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_item_i.cmd == CMD_TICK) ? ST_TREAD : ST_COUNT;
        end
      end
      ST_COUNT: begin
        state_d = act_ok ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        if (cmp_vld_q && cmp_last) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_d = (hit_q && !hit_more) ? ST_IDLE : ST_FLUSH;
      end
      ST_FLUSH: begin
        if (!pend_vld_q || out_ld_ok) begin
          state_d = ST_IDLE;
        end
      end
      ST_TREAD: begin
        if (valid_q[idx_q]) begin
          state_d = ST_TUPD;
        end else if (is_last) begin
          state_d = ST_FLUSH;
        end
      end
      ST_TUPD: begin
        if (tupd_go) begin
          state_d = is_last ? ST_FLUSH : ST_TREAD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer: control outputs
  // ---------------------------------------------------------------------
  logic              pend_set;
  out_item_t         pend_data;
  logic              out_load;
  out_item_t         out_data;
  logic              valid_set;
  logic              valid_clr;

  always_comb begin
    ram_rd_en   = 1'b0;
    ram_rd_addr = idx_q;
    ram_wr_en   = 1'b0;
    ram_wr_addr = idx_q;
    ram_wr_data = rd_entry;
    pend_set    = 1'b0;
    pend_data   = pend_q;
    out_load    = 1'b0;
    out_data    = pend_q;
    valid_set   = 1'b0;
    valid_clr   = 1'b0;
    case (state_q)
      ST_SCAN: begin
        ram_rd_en = !rd_done_q;
      end
      ST_DECIDE: begin
        // new or refreshed entry and the report's own fields as the result
        ram_wr_data.mac   = item_mac_q;
        ram_wr_data.vec   = item_vec_q;
        ram_wr_data.flag  = item_flag_q;
        ram_wr_data.timer = hold_time_q;
        pend_data.action        = ACT_BLOCK;
        pend_data.out_mac       = item_mac_q;
        pend_data.out_vector    = VEC_W'(item_vec_q);
        pend_data.out_no_vector = item_flag_q;
        pend_data.last_result   = 1'b0;
        if (hit_q) begin
          if (hit_more) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = hit_idx_q;
            pend_set    = 1'b1;
          end
        end else if (free_q) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = free_idx_q;
          valid_set   = 1'b1;
          pend_set    = 1'b1;
        end else begin
          pend_data.action = ACT_DROP;
          pend_set         = 1'b1;
        end
      end
      ST_FLUSH: begin
        out_data.last_result = 1'b1;
        out_load             = pend_vld_q && out_ld_ok;
      end
      ST_TREAD: begin
        ram_rd_en = valid_q[idx_q];
      end
      ST_TUPD: begin
        ram_wr_data.timer       = tupd_timer;
        pend_data.action        = ACT_UNBLOCK;
        pend_data.out_mac       = rd_entry.mac;
        pend_data.out_vector    = VEC_W'(rd_entry.vec);
        pend_data.out_no_vector = rd_entry.flag;
        pend_data.last_result   = 1'b0;
        out_data.last_result    = 1'b0;
        if (tupd_go) begin
          ram_wr_en = 1'b1;
          if (expire) begin
            pend_set  = 1'b1;
            valid_clr = 1'b1;
            out_load  = pend_vld_q;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      hold_time_q  <= HOLD_TIME_RST;
      valid_q      <= '0;
      idx_q        <= '0;
      rd_done_q    <= 1'b0;
      cmp_vld_q    <= 1'b0;
      hit_q        <= 1'b0;
      free_q       <= 1'b0;
      pend_vld_q   <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_valid_i) begin
        hold_time_q <= cfg_data_i;
      end

      if (valid_set) begin
        valid_q[free_idx_q] <= 1'b1;
      end else if (valid_clr) begin
        valid_q[idx_q] <= 1'b0;
      end

      // walk index
      if (in_accept || state_q == ST_COUNT) begin
        idx_q <= '0;
      end else if (state_q == ST_SCAN && ram_rd_en && !is_last) begin
        idx_q <= idx_q + IW'(1);
      end else if (state_q == ST_TREAD && !valid_q[idx_q] && !is_last) begin
        idx_q <= idx_q + IW'(1);
      end else if (state_q == ST_TUPD && tupd_go && !is_last) begin
        idx_q <= idx_q + IW'(1);
      end

      // lookup: reads run one slot ahead of the compare
      cmp_vld_q <= (state_q == ST_SCAN) && ram_rd_en;
      if (state_q == ST_COUNT) begin
        rd_done_q <= 1'b0;
        hit_q     <= 1'b0;
        free_q    <= 1'b0;
      end else begin
        if (state_q == ST_SCAN && ram_rd_en && is_last) begin
          rd_done_q <= 1'b1;
        end
        if (cmp_vld_q) begin
          if (valid_q[cmp_idx_q]) begin
            if (!hit_q && rd_entry.mac == item_mac_q) begin
              hit_q <= 1'b1;
            end
          end else if (!free_q) begin
            free_q <= 1'b1;
          end
        end
      end

      if (pend_set) begin
        pend_vld_q <= 1'b1;
      end else if (out_load) begin
        pend_vld_q <= 1'b0;
      end

      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_mac_q  <= in_item_i.mac_addr;
      item_vec_q  <= in_item_i.port_vector[VECTOR_BITS-1:0];
      item_flag_q <= in_item_i.no_vector;
    end
    if (state_q == ST_COUNT) begin
      cnt_q <= pc_cnt;
    end
    cmp_idx_q <= idx_q;
    if (cmp_vld_q) begin
      if (valid_q[cmp_idx_q]) begin
        if (!hit_q && rd_entry.mac == item_mac_q) begin
          hit_idx_q <= cmp_idx_q;
          hit_vec_q <= rd_entry.vec;
        end
      end else if (!free_q) begin
        free_idx_q <= cmp_idx_q;
      end
    end
    if (pend_set) begin
      pend_q <= pend_data;
    end
    if (out_load) begin
      out_q <= out_data;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;
  assign cfg_ready_o = 1'b1;

`ifndef SYNTH
  // A held result is replaced only in the cycle it moves to the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_vld_q && pend_set) |-> out_load)
    else $error("held result overwritten before it was sent");

  // A result is loaded only when the output register is free or draining.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_vld_q || !out_stall_i))
    else $error("output register overwritten while stalled");

  // The final result of an item returns the unit to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_data.last_result) |=> (state_q == ST_IDLE))
    else $error("final result sent but item still in progress");

  // The tick walk only rewrites occupied slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TUPD && ram_wr_en) |-> valid_q[idx_q])
    else $error("timer written back to a free slot");
`endif

endmodule

// ===== rtl/blmb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module blmb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/blmb_popcnt.sv =====
// Shared set-bit counter built from nibble lookups.
`timescale 1ns / 1ps

module blmb_popcnt #(
  parameter int unsigned WIDTH = 32,
  localparam int unsigned CNT_W = $clog2(WIDTH + 1)
) (
  input  logic [WIDTH-1:0] vec_i,
  output logic [CNT_W-1:0] count_o
);

  localparam int unsigned NIBS  = (WIDTH + 3) / 4;
  localparam int unsigned PAD_W = NIBS * 4;
  localparam logic [2:0] NIBBLE_ONES [16] = '{
    3'd0, 3'd1, 3'd1, 3'd2, 3'd1, 3'd2, 3'd2, 3'd3,
    3'd1, 3'd2, 3'd2, 3'd3, 3'd2, 3'd3, 3'd3, 3'd4
  };

  logic [PAD_W-1:0] pad;
  logic [CNT_W-1:0] sum;

  always_comb begin
    pad = PAD_W'(vec_i);
    sum = '0;
    for (int k = 0; k < NIBS; k++) begin
      sum = sum + CNT_W'(NIBBLE_ONES[pad[4*k +: 4]]);
    end
    count_o = sum;
  end

endmodule
